[sv/ibfs_pkg.sv]
// ----------------------------------------------------------------------------
// ibfs_pkg: shared types and constants of the isometric box fitter
// Register map, box and request structs, back-end states, defaults.
// ----------------------------------------------------------------------------
package ibfs_pkg;

  localparam int COORD_BITS_DEF  = 10;
  localparam int HEIGHT_BITS_DEF = 16;

  localparam int BOX_W     = 14;
  localparam int BOX_MIN_C = -8192;
  localparam int BOX_MAX_C = 8191;
  localparam int FRAC_W    = 15;
  localparam int COEF_W    = 16;
  localparam int SCALE_W   = 16;
  localparam int SDIV_W    = 8;
  localparam int SPAN_W    = BOX_W + 1;

  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_COS     = 3'd0;
  localparam logic [2:0] REG_SIN     = 3'd1;
  localparam logic [2:0] REG_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_EXTENT  = 3'd3;
  localparam logic [2:0] REG_DIVISOR = 3'd4;

  localparam logic [COEF_W-1:0]  COS_RST     = 16'd28378;
  localparam logic [COEF_W-1:0]  SIN_RST     = 16'd16384;
  localparam logic [COEF_W-1:0]  HEIGHT_RST  = 16'd3277;
  localparam logic [COEF_W-1:0]  EXTENT_RST  = 16'd1000;
  localparam logic [SDIV_W-1:0]  DIVISOR_RST = 8'd1;

  localparam int OUT_W = 4 * BOX_W + SCALE_W;

  typedef struct packed {
    logic [COEF_W-1:0] cos_coef;
    logic [COEF_W-1:0] sin_coef;
    logic [COEF_W-1:0] height_coef;
    logic [COEF_W-1:0] fit_extent;
    logic [SDIV_W-1:0] scale_divisor;
  } cfg_t;

  typedef struct packed {
    logic signed [BOX_W-1:0] y_max;
    logic signed [BOX_W-1:0] y_min;
    logic signed [BOX_W-1:0] x_max;
    logic signed [BOX_W-1:0] x_min;
  } box_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV_SPAN,
    BK_DIV_SCALE,
    BK_OUT
  } back_state_t;

endpackage

[sv/ibfs_front.sv]
// ----------------------------------------------------------------------------
// ibfs_front: projection pipeline and running bounding box
// Projects each point in two stages, folds it into the box and pushes a
// snapshot of the box into the queue on the last point of a map.
// ----------------------------------------------------------------------------
module ibfs_front
  import ibfs_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
  parameter int IN_W        = ((2 * COORD_BITS + HEIGHT_BITS + 7) / 8) * 8,
  parameter int QCW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  logic            in_tlast,
  input  cfg_t            cfg,
  input  logic [QCW-1:0]  q_level,
  output logic            q_push,
  output box_t            q_push_box
);

  localparam int PX_W = COORD_BITS + 18;
  localparam int PS_W = COORD_BITS + 19;
  localparam int PH_W = HEIGHT_BITS + 17;
  localparam int PW   = ((PS_W > PH_W) ? PS_W : PH_W) + 1;
  localparam logic signed [PW-1:0] LO_C   = PW'(BOX_MIN_C);
  localparam logic signed [PW-1:0] HI_C   = PW'(BOX_MAX_C);
  localparam logic signed [PW-1:0] BIAS_C = PW'((1 << FRAC_W) - 1);

  logic [COORD_BITS-1:0]         gx, gy;
  logic signed [HEIGHT_BITS-1:0] gz;
  logic signed [COORD_BITS:0]    dxy;
  logic signed [COORD_BITS+1:0]  sxy;
  logic signed [COEF_W:0]        cos_s, sin_s, hc_s;
  logic signed [PX_W-1:0]        prod_x;
  logic signed [PS_W-1:0]        prod_s;
  logic signed [PH_W-1:0]        prod_h;

  logic                   s1_valid_r, s1_last_r;
  logic signed [PX_W-1:0] s1_px_r;
  logic signed [PS_W-1:0] s1_ps_r;
  logic signed [PH_W-1:0] s1_ph_r;

  logic                    s2_valid_r, s2_last_r;
  logic signed [BOX_W-1:0] s2_px_r, s2_py_r;

  box_t run_r, run_nxt, fold;
  logic signed [PW-1:0]  sum_y;
  logic [QCW+1:0]        occupied;

  function automatic logic signed [BOX_W-1:0] proj(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    logic signed [PW-1:0] q;
    t = v + (v[PW-1] ? BIAS_C : '0);
    q = t >>> FRAC_W;
    if (q < LO_C) begin
      return BOX_W'(BOX_MIN_C);
    end else if (q > HI_C) begin
      return BOX_W'(BOX_MAX_C);
    end
    return q[BOX_W-1:0];
  endfunction

  // Field unpack and products
  assign gx    = in_tdata[COORD_BITS-1:0];
  assign gy    = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign gz    = in_tdata[2*COORD_BITS+HEIGHT_BITS-1:2*COORD_BITS];
  assign dxy   = $signed({1'b0, gx}) - $signed({1'b0, gy});
  assign sxy   = $signed({2'b00, gx} + {2'b00, gy});
  assign cos_s = $signed({1'b0, cfg.cos_coef});
  assign sin_s = $signed({1'b0, cfg.sin_coef});
  assign hc_s  = $signed({1'b0, cfg.height_coef});
  assign prod_x = dxy * cos_s;
  assign prod_s = sxy * sin_s;
  assign prod_h = gz * hc_s;

  // Hold back when the queue could not take every last point in flight
  assign occupied  = (QCW+2)'(q_level) + (QCW+2)'(s1_valid_r & s1_last_r)
                   + (QCW+2)'(s2_valid_r & s2_last_r);
  assign in_tready = occupied < (QCW+2)'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      run_r      <= '0;
    end else begin
      s1_valid_r <= in_tvalid & in_tready;
      s2_valid_r <= s1_valid_r;
      run_r      <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= in_tlast;
    s1_px_r   <= prod_x;
    s1_ps_r   <= prod_s;
    s1_ph_r   <= prod_h;
    s2_last_r <= s1_last_r;
    s2_px_r   <= proj(PW'(s1_px_r));
    s2_py_r   <= proj(sum_y);
  end

  assign sum_y = PW'(s1_ps_r) - PW'(s1_ph_r);

  // Fold the projected point into the box
  always_comb begin
    fold       = run_r;
    if (s2_px_r < run_r.x_min) fold.x_min = s2_px_r;
    if (s2_px_r > run_r.x_max) fold.x_max = s2_px_r;
    if (s2_py_r < run_r.y_min) fold.y_min = s2_py_r;
    if (s2_py_r > run_r.y_max) fold.y_max = s2_py_r;
    run_nxt    = run_r;
    q_push     = 1'b0;
    q_push_box = fold;
    if (s2_valid_r) begin
      if (s2_last_r) begin
        q_push  = 1'b1;
        run_nxt = '0;
      end else begin
        run_nxt = fold;
      end
    end
  end

endmodule

[sv/ibfs_queue.sv]
// ----------------------------------------------------------------------------
// ibfs_queue: short queue of finished boxes
// Decouples the projection pipeline from the scale divider.
// ----------------------------------------------------------------------------
module ibfs_queue
  import ibfs_pkg::*;
#(
  parameter int QCW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  box_t           push_box,
  input  logic           pop,
  output box_t           head,
  output logic           empty,
  output logic [QCW-1:0] level
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  box_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   level_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      case ({push, pop})
        2'b10:   level_r <= level_r + 1'b1;
        2'b01:   level_r <= level_r - 1'b1;
        default: level_r <= level_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_box;
  end

  assign head  = slot_r[rd_ptr_r];
  assign empty = (level_r == '0);
  assign level = level_r;

endmodule

[sv/ibfs_div.sv]
// ----------------------------------------------------------------------------
// ibfs_div: restoring divider, one quotient bit per cycle
// Unsigned DIV_W-bit division; done pulses with the last quotient bit.
// ----------------------------------------------------------------------------
module ibfs_div
  import ibfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     rem_r, quo_r, dsr_r;
  logic [DIV_W-1:0]     rem_nxt, quo_nxt;
  logic [DIV_W:0]       trial;

  always_comb begin
    trial = {rem_r, quo_r[DIV_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = DIV_W'(trial - {1'b0, dsr_r});
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[sv/ibfs_back.sv]
// ----------------------------------------------------------------------------
// ibfs_back: fit scale sequencer and result register
// Takes a box from the queue, runs two divisions on the shared divider
// and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module ibfs_back
  import ibfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             q_empty,
  input  box_t             q_head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  back_state_t          state_r, state_nxt;
  box_t                 box_r, box_nxt;
  logic [SCALE_W-1:0]   scale_r, scale_nxt;
  div_req_t             dreq;
  div_rsp_t             drsp;
  logic signed [SPAN_W-1:0] xdiff, ydiff;
  logic [SPAN_W-1:0]    span;
  logic [SDIV_W-1:0]    sdiv;

  ibfs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Spans are never negative: the box always holds the origin
  assign xdiff = SPAN_W'(q_head.x_max) - SPAN_W'(q_head.x_min);
  assign ydiff = SPAN_W'(q_head.y_max) - SPAN_W'(q_head.y_min);
  assign sdiv  = (cfg.scale_divisor == '0) ? SDIV_W'(1) : cfg.scale_divisor;

  always_comb begin
    span = (xdiff > ydiff) ? xdiff : ydiff;
    if (span == '0) span = SPAN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    box_r   <= box_nxt;
    scale_r <= scale_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    box_nxt       = box_r;
    scale_nxt     = scale_r;
    q_pop         = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = cfg.fit_extent;
    dreq.divisor  = DIV_W'(span);
    out_tvalid    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          box_nxt    = q_head;
          dreq.start = 1'b1;
          state_nxt  = BK_DIV_SPAN;
        end
      end
      BK_DIV_SPAN: begin
        dreq.dividend = drsp.quotient;
        dreq.divisor  = DIV_W'(sdiv);
        if (drsp.done) begin
          dreq.start = 1'b1;
          state_nxt  = BK_DIV_SCALE;
        end
      end
      BK_DIV_SCALE: begin
        if (drsp.done) begin
          scale_nxt = (drsp.quotient == '0) ? SCALE_W'(1) : SCALE_W'(drsp.quotient);
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign out_tdata = {scale_r, box_r.y_max, box_r.y_min, box_r.x_max, box_r.x_min};

endmodule

[sv/isometric_bbox_fit_scale_core.sv]
// ----------------------------------------------------------------------------
// isometric_bbox_fit_scale_core: isometric projection bounding box fitter
// Projects grid points, tracks their bounding box and fits a scale to it.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one grid point per transfer; in_tlast marks the final point of
//           a map. A point is taken every cycle while in_tready is high.
//   out_* : one transfer per map with the box and the fit scale.
//   cfg_* : APB register port, write only while the block is idle.
// Path: a result passes the two projection stages and the queue, then
//   two passes of the shared restoring divider (16 quotient bits each;
//   extent / span, then / divisor) before it is offered on out_*.
// Flow: points stream at one per cycle while in_tready is high; the back
//   end takes a new box only once the last result is taken. Up to four
//   finished boxes wait in the queue.
// Stall: while out_tready is low the result holds and points keep flowing
//   until the queue, counting last points still in the projection stages,
//   is full; in_tready then drops.
// Reset: synchronous, active low. The box returns to the origin, the queue
//   empties and the registers take their default values.
// ----------------------------------------------------------------------------
module isometric_bbox_fit_scale_core
  import ibfs_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
  parameter int IN_W        = ((2 * COORD_BITS + HEIGHT_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata, lowest bit up: grid_x, grid_y, height, zero fill
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              in_tlast,
  // out_tdata, lowest bit up: box_x_min, box_x_max, box_y_min, box_y_max,
  // fit_scale
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cfg_t           cfg_r;
  logic           cfg_wr;
  logic [2:0]     cfg_idx;
  logic           q_push, q_pop, q_empty;
  box_t           q_push_box, q_head;
  logic [QCW-1:0] q_level;

  // Register file: written on the access phase of an APB write
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_coef      <= COS_RST;
      cfg_r.sin_coef      <= SIN_RST;
      cfg_r.height_coef   <= HEIGHT_RST;
      cfg_r.fit_extent    <= EXTENT_RST;
      cfg_r.scale_divisor <= DIVISOR_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COS:     cfg_r.cos_coef      <= cfg_pwdata[COEF_W-1:0];
        REG_SIN:     cfg_r.sin_coef      <= cfg_pwdata[COEF_W-1:0];
        REG_HEIGHT:  cfg_r.height_coef   <= cfg_pwdata[COEF_W-1:0];
        REG_EXTENT:  cfg_r.fit_extent    <= cfg_pwdata[COEF_W-1:0];
        REG_DIVISOR: cfg_r.scale_divisor <= cfg_pwdata[SDIV_W-1:0];
        default:     ;
      endcase
    end
  end

  // Read back; addresses past the map return zero
  always_comb begin
    case (cfg_idx)
      REG_COS:     cfg_prdata = CFG_DW'(cfg_r.cos_coef);
      REG_SIN:     cfg_prdata = CFG_DW'(cfg_r.sin_coef);
      REG_HEIGHT:  cfg_prdata = CFG_DW'(cfg_r.height_coef);
      REG_EXTENT:  cfg_prdata = CFG_DW'(cfg_r.fit_extent);
      REG_DIVISOR: cfg_prdata = CFG_DW'(cfg_r.scale_divisor);
      default:     cfg_prdata = '0;
    endcase
  end

  ibfs_front #(
    .COORD_BITS  (COORD_BITS),
    .HEIGHT_BITS (HEIGHT_BITS),
    .IN_W        (IN_W),
    .QCW         (QCW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg        (cfg_r),
    .q_level    (q_level),
    .q_push     (q_push),
    .q_push_box (q_push_box)
  );

  ibfs_queue #(
    .QCW (QCW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_box (q_push_box),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .level    (q_level)
  );

  ibfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The front end must never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_level < QCW'(QUEUE_DEPTH)))
    else $error("box queue overflow");

  // The back end only takes boxes that are there
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("box queue underflow");

  // Every delivered box holds the origin and carries a non-zero scale
  a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[13:0]) <= 0) && ($signed(out_tdata[27:14]) >= 0)
                && ($signed(out_tdata[41:28]) <= 0) && ($signed(out_tdata[55:42]) >= 0)
                && (out_tdata[71:56] != '0))
    else $error("result box or scale out of range");

endmodule

[dv/tb_isometric_bbox_fit_scale_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_isometric_bbox_fit_scale_core: self-checking bench of the box fitter
// Streams grid-point maps through the core under several register settings,
// predicts each map's bounding box and fit scale, and compares every result
// transfer field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_isometric_bbox_fit_scale_core;
  import ibfs_pkg::*;

  localparam int GRID_W = COORD_BITS_DEF;
  localparam int ZED_W  = HEIGHT_BITS_DEF;
  localparam int IN_W   = ((2 * GRID_W + ZED_W + 7) / 8) * 8;
  localparam int PAD_W  = IN_W - 2 * GRID_W - ZED_W;

  // Indexes past the register map; writes there must leave everything alone
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Cycles to let pass once nothing is pending
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct {
    logic signed [BOX_W-1:0] x_min;
    logic signed [BOX_W-1:0] x_max;
    logic signed [BOX_W-1:0] y_min;
    logic signed [BOX_W-1:0] y_max;
    logic [SCALE_W-1:0]      scale;
  } fit_t;

  typedef struct {
    logic [GRID_W-1:0] gx;
    logic [GRID_W-1:0] gy;
    logic [ZED_W-1:0]  z;
    logic              last;
    bit                typed;
    fit_t              fit;
  } point_row_t;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  // in_tdata, lowest bit up: grid_x, grid_y, height, zero fill
  logic [IN_W-1:0]   in_tdata    = '0;
  logic              in_tlast    = 1'b0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  // out_tdata, lowest bit up: box_x_min, box_x_max, box_y_min, box_y_max,
  // fit_scale
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Predictor copy of the registers and of the running box
  logic [COEF_W-1:0] cos_q;
  logic [COEF_W-1:0] sin_q;
  logic [COEF_W-1:0] zed_q;
  logic [COEF_W-1:0] extent_q;
  logic [SDIV_W-1:0] divisor_q;
  longint            box_x_lo, box_x_hi, box_y_lo, box_y_hi;

  fit_t       pending_fits[$];
  point_row_t point_rows[$];
  fit_t       fit_want;
  int         fault_count = 0;
  int         fits_seen   = 0;
  int         rand_points = 0;
  bit         in_calm     = 1'b0;

  isometric_bbox_fit_scale_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #2_000_000;
    $display("FAIL isometric_bbox_fit_scale_core");
    $finish;
  end

  function automatic longint clip_box(input longint v);
    if (v < BOX_MIN_C) return BOX_MIN_C;
    if (v > BOX_MAX_C) return BOX_MAX_C;
    return v;
  endfunction

  // Project one point, widen the box, and on the last point of a map close
  // the box into a fit result and return the box to the origin.
  task automatic fold_point(input logic [GRID_W-1:0] gx, input logic [GRID_W-1:0] gy,
                            input logic [ZED_W-1:0] z, input logic last,
                            output bit closed, output fit_t fit);
    longint one_q, px, py, xs, ys, span, div, q;
    one_q = longint'(1) << FRAC_W;
    // signed division truncates toward zero, as the projection needs
    px = clip_box(((longint'(gx) - longint'(gy)) * longint'(cos_q)) / one_q);
    py = clip_box(((longint'(gx) + longint'(gy)) * longint'(sin_q)
                   - longint'($signed(z)) * longint'(zed_q)) / one_q);
    if (px < box_x_lo) box_x_lo = px;
    if (px > box_x_hi) box_x_hi = px;
    if (py < box_y_lo) box_y_lo = py;
    if (py > box_y_hi) box_y_hi = py;
    closed = last;
    fit.x_min = box_x_lo[BOX_W-1:0];
    fit.x_max = box_x_hi[BOX_W-1:0];
    fit.y_min = box_y_lo[BOX_W-1:0];
    fit.y_max = box_y_hi[BOX_W-1:0];
    fit.scale = '0;
    if (last) begin
      xs   = box_x_hi - box_x_lo;
      ys   = box_y_hi - box_y_lo;
      span = (xs > ys) ? xs : ys;
      if (span < 1) span = 1;
      div  = (divisor_q == 0) ? 1 : longint'(divisor_q);
      q    = (longint'(extent_q) / span) / div;
      if (q < 1) q = 1;
      fit.scale = q[SCALE_W-1:0];
      box_x_lo  = 0;
      box_x_hi  = 0;
      box_y_lo  = 0;
      box_y_hi  = 0;
    end
  endtask

  // APB write: setup cycle, access cycle, then release the bus
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_COS:     cos_q     = value[COEF_W-1:0];
      REG_SIN:     sin_q     = value[COEF_W-1:0];
      REG_HEIGHT:  zed_q     = value[COEF_W-1:0];
      REG_EXTENT:  extent_q  = value[COEF_W-1:0];
      REG_DIVISOR: divisor_q = value[SDIV_W-1:0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DW-1:0] c, input logic [CFG_DW-1:0] s,
                               input logic [CFG_DW-1:0] h, input logic [CFG_DW-1:0] e,
                               input logic [CFG_DW-1:0] d);
    write_reg(REG_COS, c);
    write_reg(REG_SIN, s);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_EXTENT, e);
    write_reg(REG_DIVISOR, d);
  endtask

  // Offer one point, hold it until the core takes it, then predict.
  // A typed row supplies its own expected result in place of the predictor's.
  task automatic send_point(input logic [GRID_W-1:0] gx, input logic [GRID_W-1:0] gy,
                            input logic [ZED_W-1:0] z, input logic last,
                            input bit typed, input fit_t given);
    bit   closed;
    fit_t fit;
    if (!in_calm && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{PAD_W{1'b0}}, z, gy, gx};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fold_point(gx, gy, z, last, closed, fit);
    if (closed) begin
      if (typed) pending_fits.push_back(given);
      else       pending_fits.push_back(fit);
    end
  endtask

  task automatic add_row(input logic [GRID_W-1:0] gx, input logic [GRID_W-1:0] gy,
                         input logic [ZED_W-1:0] z, input logic last, input bit typed,
                         input int xmn, input int xmx, input int ymn, input int ymx,
                         input int sc);
    point_row_t row;
    row.gx        = gx;
    row.gy        = gy;
    row.z         = z;
    row.last      = last;
    row.typed     = typed;
    row.fit.x_min = xmn[BOX_W-1:0];
    row.fit.x_max = xmx[BOX_W-1:0];
    row.fit.y_min = ymn[BOX_W-1:0];
    row.fit.y_max = ymx[BOX_W-1:0];
    row.fit.scale = sc[SCALE_W-1:0];
    point_rows.push_back(row);
  endtask

  // One map of random length; coordinates and heights are drawn per map from
  // a small, a full-range or an extremes-only pool.
  task automatic send_random_map(output int sent);
    int                pick, len, cmode, zmode;
    logic [GRID_W-1:0] gx, gy;
    logic [ZED_W-1:0]  z;
    fit_t              none;
    pick  = $urandom_range(0, 99);
    len   = (pick < 10) ? 1 : (pick < 80) ? $urandom_range(2, 6) : $urandom_range(7, 24);
    cmode = $urandom_range(0, 2);
    zmode = $urandom_range(0, 2);
    none  = '{default: '0};
    for (int i = 0; i < len; i++) begin
      case (cmode)
        0: begin
          gx = GRID_W'($urandom_range(0, 15));
          gy = GRID_W'($urandom_range(0, 15));
        end
        1: begin
          gx = GRID_W'($urandom);
          gy = GRID_W'($urandom);
        end
        default: begin
          gx = $urandom_range(0, 1) ? {GRID_W{1'b1}} : '0;
          gy = $urandom_range(0, 1) ? {GRID_W{1'b1}} : '0;
        end
      endcase
      case (zmode)
        0: z = ZED_W'($urandom_range(0, 127)) - ZED_W'(64);
        1: z = ZED_W'($urandom);
        default: begin
          case ($urandom_range(0, 2))
            0:       z = 16'h8000;
            1:       z = 16'h7FFF;
            default: z = 16'h0000;
          endcase
        end
      endcase
      // a stretch with no source gaps at all
      in_calm = (rand_points >= 180 && rand_points < 260);
      send_point(gx, gy, z, i == len - 1, 1'b0, none);
      rand_points++;
    end
    sent = len;
  endtask

  // Wait for every predicted result, then let the back end empty out
  task automatic settle();
    int guard;
    guard = 0;
    while (pending_fits.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_fits.size() != 0) begin
      $display("%0t: %0d box result(s) expected but never arrived",
               $time, pending_fits.size());
      fault_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_maps(input int quota);
    int done, n;
    done = 0;
    while (done < quota) begin
      send_random_map(n);
      done += n;
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    settle();
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fault_count++;
    end
  endtask

  // Result side: stall at random, with a calm stretch, and check every transfer
  always @(posedge clk) begin
    out_tready <= (fits_seen >= 30 && fits_seen < 50) || ($urandom_range(0, 99) >= 13);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_fits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h", $time, out_tdata);
        fault_count++;
      end else begin
        fit_want = pending_fits.pop_front();
        check_field("box_x_min", fit_want.x_min, $signed(out_tdata[BOX_W-1:0]));
        check_field("box_x_max", fit_want.x_max, $signed(out_tdata[2*BOX_W-1:BOX_W]));
        check_field("box_y_min", fit_want.y_min, $signed(out_tdata[3*BOX_W-1:2*BOX_W]));
        check_field("box_y_max", fit_want.y_max, $signed(out_tdata[4*BOX_W-1:3*BOX_W]));
        check_field("fit_scale", fit_want.scale, out_tdata[OUT_W-1:4*BOX_W]);
      end
      fits_seen++;
    end
  end

  initial begin
    cos_q     = COS_RST;
    sin_q     = SIN_RST;
    zed_q     = HEIGHT_RST;
    extent_q  = EXTENT_RST;
    divisor_q = DIVISOR_RST;
    box_x_lo  = 0;
    box_x_hi  = 0;
    box_y_lo  = 0;
    box_y_hi  = 0;

    // Directed rows under the reset registers. Typed rows: single-point maps
    // whose box and scale are plain arithmetic.
    // origin alone: zero span taken as one, scale is the full extent
    add_row(0, 0, 16'h0000, 1, 1, 0, 0, 0, 0, 1000);
    // far column and far row: extremes of both grid fields
    add_row(10'h3FF, 0, 16'h0000, 1, 1, 0, 885, 0, 511, 1);
    add_row(0, 10'h3FF, 16'h0000, 1, 1, -885, 0, 0, 511, 1);
    // deepest height at the far corner: scale rounds to zero, clamped to one
    add_row(10'h3FF, 10'h3FF, 16'h8000, 1, 1, 0, 0, 0, 4300, 1);
    add_row(0, 0, 16'h7FFF, 1, 1, 0, 0, -3276, 0, 1);
    // fractions below one pixel truncate toward zero, both signs
    add_row(1, 0, 16'h0000, 1, 1, 0, 0, 0, 0, 1000);
    add_row(0, 1, 16'h0000, 1, 1, 0, 0, 0, 0, 1000);
    add_row(0, 0, 16'hFFFF, 1, 1, 0, 0, 0, 0, 1000);
    add_row(0, 0, 16'd19, 1, 1, 0, 0, -1, 0, 1000);
    // multi-point maps, left to the predictor
    add_row(10, 3, 16'd200, 0, 0, 0, 0, 0, 0, 0);
    add_row(2, 9, 16'hFE70, 0, 0, 0, 0, 0, 0, 0);
    add_row(500, 700, 16'd1000, 0, 0, 0, 0, 0, 0, 0);
    add_row(10'h3FF, 10'h3FF, 16'h7FFF, 1, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 16'h0000, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 16'h0000, 0, 0, 0, 0, 0, 0, 0);
    add_row(3, 0, 16'h0000, 1, 0, 0, 0, 0, 0, 0);
    // alternating bit patterns on every field, then field extremes
    add_row(10'h155, 10'h2AA, 16'h5555, 0, 0, 0, 0, 0, 0, 0);
    add_row(10'h2AA, 10'h155, 16'hAAAA, 1, 0, 0, 0, 0, 0, 0);
    add_row(10'h3FF, 0, 16'h8000, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 10'h3FF, 16'h7FFF, 1, 0, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (point_rows[r])
      send_point(point_rows[r].gx, point_rows[r].gy, point_rows[r].z,
                 point_rows[r].last, point_rows[r].typed, point_rows[r].fit);
    run_maps(65);

    // Largest coefficients, just under two: projections can saturate at the box limits
    apply_setting(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFF);
    run_maps(70);

    // All zero: every point lands on the origin, zero divisor taken as one,
    // zero extent gives scale one. Spare indexes must not disturb anything.
    apply_setting(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h0000_1234);
    run_maps(70);

    // Exactly one in Q1.15, smallest extent
    apply_setting(32'h8000, 32'h8000, 32'h8000, 32'd1, 32'd1);
    run_maps(70);

    // Random registers, upper bus bits included; drop what lies past the width
    apply_setting($urandom, $urandom, $urandom, $urandom, $urandom);
    run_maps(70);

    // Largest extent and unit divisor: small maps reach the top of the scale
    apply_setting(32'd23170, 32'd23170, 32'd1, 32'hFFFF, 32'd1);
    run_maps(70);

    if (fault_count == 0)
      $display("PASS isometric_bbox_fit_scale_core");
    else
      $display("FAIL isometric_bbox_fit_scale_core");
    $finish;
  end

endmodule
